// ===== sv/crc_checked_header_deframer_macros.svh =====
// Assertion macros used by the deframer's header parser RTL file.
`ifndef CRC_CHECKED_HEADER_DEFRAMER_MACROS_SVH
`define CRC_CHECKED_HEADER_DEFRAMER_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define CHDF_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define CHDF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/chdf_pkg.sv =====
// Package with the constants, result type and CRC function of the header deframer.
`timescale 1ns / 1ps
`default_nettype none
package chdf_pkg;

  localparam int unsigned HdrLen = 34;
  localparam int unsigned CrcLen = 32;
  localparam int unsigned CntW   = 6;
  localparam int unsigned NumHdrBytes = HdrLen - 1;
  // Bytes 0..30 carry the unpacked fields; byte 31 only enters the CRC.
  localparam int unsigned FieldBytes = 31;
  localparam int unsigned FieldIdxW  = $clog2(FieldBytes);

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;

  localparam logic [1:0] StatusOk     = 2'd0;
  localparam logic [1:0] StatusCrcErr = 2'd1;
  localparam logic [1:0] StatusShort  = 2'd2;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] dest_addr;
    logic [15:0] src_addr;
    logic [63:0] conv_id_high;
    logic [63:0] conv_id_low;
    logic [31:0] msg_number;
    logic [15:0] seq_num;
    logic [15:0] seq_total;
    logic [7:0]  kind_code;
    logic [7:0]  flag_bits;
    logic [7:0]  media_code;
    logic [15:0] stored_crc;
  } hdr_result_t;

  // CRC-16/CCITT-FALSE update over one byte, MSB first.
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== sv/crc_checked_header_deframer.sv =====
// Top level of the CRC-checked frame header deframer.
`timescale 1ns / 1ps
`default_nettype none
// Takes one frame byte per transfer and sustains one byte per cycle while no
// result is held back, since the byte counter, the CRC-16/CCITT-FALSE byte update
// and the header byte store all settle between the input register and the result
// register. A result passes through the input register and the result register
// after the transfer of the byte that causes it: the header on byte 33 with status
// ok or crc mismatch, or a short status with zeroed fields when the frame's last
// byte comes earlier. Bytes after the header give no result. The result register
// frees the input side, so bytes that give no result keep flowing while a result
// waits; a byte that would give a second result waits until the first one is taken.
module crc_checked_header_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        frame_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [15:0] dest_addr_o,
  output logic [15:0] src_addr_o,
  output logic [63:0] conv_id_high_o,
  output logic [63:0] conv_id_low_o,
  output logic [31:0] msg_number_o,
  output logic [15:0] seq_num_o,
  output logic [15:0] seq_total_o,
  output logic [7:0]  kind_code_o,
  output logic [7:0]  flag_bits_o,
  output logic [7:0]  media_code_o,
  output logic [15:0] stored_crc_o
);
  import chdf_pkg::*;

  logic        stage_valid;
  logic [7:0]  stage_byte;
  logic        stage_last;
  logic        step;
  logic        res_due;
  logic        res_valid;
  hdr_result_t res;
  logic        out_valid_q, out_valid_d;
  hdr_result_t out_q;

  // The staged byte moves on unless its result would find the result register occupied.
  assign step = stage_valid && (!res_due || !out_valid_q || out_ready_i);

  chdf_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .rx_byte_i    (rx_byte_i),
    .frame_last_i (frame_last_i),
    .advance_i    (step),
    .valid_o      (stage_valid),
    .byte_o       (stage_byte),
    .last_o       (stage_last)
  );

  chdf_hdr_parse u_hdr_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (stage_byte),
    .last_i      (stage_last),
    .res_due_o   (res_due),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (res_valid) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_q.status;
  assign dest_addr_o    = out_q.dest_addr;
  assign src_addr_o     = out_q.src_addr;
  assign conv_id_high_o = out_q.conv_id_high;
  assign conv_id_low_o  = out_q.conv_id_low;
  assign msg_number_o   = out_q.msg_number;
  assign seq_num_o      = out_q.seq_num;
  assign seq_total_o    = out_q.seq_total;
  assign kind_code_o    = out_q.kind_code;
  assign flag_bits_o    = out_q.flag_bits;
  assign media_code_o   = out_q.media_code;
  assign stored_crc_o   = out_q.stored_crc;

endmodule
`default_nettype wire

// ===== sv/chdf_in_reg.sv =====
// Input register stage that holds one byte transfer until the parser takes it.
`timescale 1ns / 1ps
`default_nettype none
module chdf_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  input  logic       frame_last_i,
  input  logic       advance_i,
  output logic       valid_o,
  output logic [7:0] byte_o,
  output logic       last_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       last_q;

  // The register can refill in the same cycle that its item moves on.
  assign in_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= rx_byte_i;
      last_q <= frame_last_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;
  assign last_o  = last_q;

endmodule
`default_nettype wire

// ===== sv/chdf_hdr_parse.sv =====
// Byte counter, running CRC, header byte store and result formation.
`timescale 1ns / 1ps
`default_nettype none
`include "crc_checked_header_deframer_macros.svh"
module chdf_hdr_parse (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [7:0]            byte_i,
  input  logic                  last_i,
  output logic                  res_due_o,
  output logic                  res_valid_o,
  output chdf_pkg::hdr_result_t res_o
);
  import chdf_pkg::*;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [15:0]     crc_q, crc_d;
  logic [7:0]      hdr_q [FieldBytes];
  logic [7:0]      crc_lo_q;
  logic            in_hdr;
  logic            at_crc_hi;
  logic [15:0]     stored;

  assign in_hdr    = cnt_q < CntW'(NumHdrBytes);
  assign at_crc_hi = cnt_q == CntW'(NumHdrBytes);
  assign stored    = {byte_i, crc_lo_q};

  always_comb begin
    cnt_d = cnt_q;
    crc_d = crc_q;
    if (step_i) begin
      if (in_hdr) begin
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q < CntW'(CrcLen)) begin
          crc_d = crc16_byte(crc_q, byte_i);
        end
      end else begin
        cnt_d = CntW'(HdrLen);
      end
      if (last_i) begin
        cnt_d = '0;
        crc_d = CrcInit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      crc_q <= CrcInit;
    end else begin
      cnt_q <= cnt_d;
      crc_q <= crc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && cnt_q < CntW'(FieldBytes)) begin
      hdr_q[cnt_q[FieldIdxW-1:0]] <= byte_i;
    end
    if (step_i && cnt_q == CntW'(NumHdrBytes - 1)) begin
      crc_lo_q <= byte_i;
    end
  end

  // The staged byte produces a result if it ends a short frame or completes the header.
  assign res_due_o   = (in_hdr && last_i) || at_crc_hi;
  assign res_valid_o = step_i && res_due_o;

  always_comb begin
    res_o = '0;
    if (at_crc_hi) begin
      res_o.status       = (stored == crc_q) ? StatusOk : StatusCrcErr;
      res_o.dest_addr    = {hdr_q[1], hdr_q[0]};
      res_o.src_addr     = {hdr_q[3], hdr_q[2]};
      res_o.conv_id_high = {hdr_q[4], hdr_q[5], hdr_q[6], hdr_q[7],
                            hdr_q[8], hdr_q[9], hdr_q[10], hdr_q[11]};
      res_o.conv_id_low  = {hdr_q[12], hdr_q[13], hdr_q[14], hdr_q[15],
                            hdr_q[16], hdr_q[17], hdr_q[18], hdr_q[19]};
      res_o.msg_number   = {hdr_q[23], hdr_q[22], hdr_q[21], hdr_q[20]};
      res_o.seq_num      = {hdr_q[25], hdr_q[24]};
      res_o.seq_total    = {hdr_q[27], hdr_q[26]};
      res_o.kind_code    = hdr_q[28];
      res_o.flag_bits    = hdr_q[29];
      res_o.media_code   = hdr_q[30];
      res_o.stored_crc   = stored;
    end else begin
      res_o.status = StatusShort;
    end
  end

  `CHDF_ASSERT_IMPL(a_cnt_range, 1'b1, cnt_q <= CntW'(HdrLen))
  `CHDF_ASSERT_NEXT(a_last_resets, step_i && last_i, cnt_q == '0 && crc_q == CrcInit)
  `CHDF_ASSERT_IMPL(a_hdr_at_33, res_valid_o && res_o.status != StatusShort, at_crc_hi)
  `CHDF_ASSERT_IMPL(a_skip_quiet, step_i && cnt_q == CntW'(HdrLen), !res_valid_o)

endmodule
`default_nettype wire

// ===== test/crc_checked_header_deframer_tb.sv =====
// Self-checking testbench for the CRC-checked frame header deframer.
`timescale 1ns / 1ps
module crc_checked_header_deframer_tb;
  import chdf_pkg::*;

  localparam int CycleLimit = 150000;
  localparam int HoldCycles = 200;
  localparam int RandBytes  = 1250;

  // Fill styles for header and frame content.
  localparam int FillRandom  = 0;
  localparam int FillZeros   = 1;
  localparam int FillOnes    = 2;
  localparam int FillCorners = 3;

  // Keeps its own copy of the deframer state and queues the result that a byte should produce, if any.
  class header_checker;
    logic [5:0]  byte_cnt;
    logic [15:0] crc;
    logic [7:0]  hdr_mem [NumHdrBytes];
    hdr_result_t due_headers [$];
    int errors;
    int seen_ok;
    int seen_bad;
    int seen_short;

    function new();
      byte_cnt   = '0;
      crc        = CrcInit;
      errors     = 0;
      seen_ok    = 0;
      seen_bad   = 0;
      seen_short = 0;
      foreach (hdr_mem[i]) hdr_mem[i] = '0;
    endfunction

    // Bit-serial CRC-16 update, message bits taken MSB first.
    static function logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
        fb = c[15] ^ b[i];
        c  = {c[14:0], 1'b0};
        if (fb) c = c ^ CrcPoly;
      end
      return c;
    endfunction

    function int pending();
      return due_headers.size();
    endfunction

    function void take_byte(logic [7:0] b, logic last);
      hdr_result_t want;
      logic [15:0] stored;
      want = '0;
      if (byte_cnt < HdrLen - 1) begin
        hdr_mem[byte_cnt] = b;
        if (byte_cnt < CrcLen) crc = crc_byte(crc, b);
        byte_cnt = byte_cnt + 6'd1;
        if (last) begin
          want.status = StatusShort;
          due_headers.push_back(want);
        end
      end else if (byte_cnt == HdrLen - 1) begin
        // The stored CRC is byte 32 low and the current byte high.
        stored = {b, hdr_mem[HdrLen - 2]};
        want.status     = (stored == crc) ? StatusOk : StatusCrcErr;
        want.dest_addr  = {hdr_mem[1], hdr_mem[0]};
        want.src_addr   = {hdr_mem[3], hdr_mem[2]};
        for (int i = 0; i < 8; i++) begin
          want.conv_id_high = {want.conv_id_high[55:0], hdr_mem[4 + i]};
          want.conv_id_low  = {want.conv_id_low[55:0], hdr_mem[12 + i]};
        end
        want.msg_number = {hdr_mem[23], hdr_mem[22], hdr_mem[21], hdr_mem[20]};
        want.seq_num    = {hdr_mem[25], hdr_mem[24]};
        want.seq_total  = {hdr_mem[27], hdr_mem[26]};
        want.kind_code  = hdr_mem[28];
        want.flag_bits  = hdr_mem[29];
        want.media_code = hdr_mem[30];
        want.stored_crc = stored;
        byte_cnt = 6'(HdrLen);
        due_headers.push_back(want);
      end
      if (last) begin
        byte_cnt = '0;
        crc      = CrcInit;
      end
    endfunction

    function void diff(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_header(hdr_result_t got);
      hdr_result_t want;
      if (due_headers.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d",
                 $time, got.status);
        errors++;
        return;
      end
      want = due_headers.pop_front();
      diff("status", 64'(want.status), 64'(got.status));
      diff("dest_addr", 64'(want.dest_addr), 64'(got.dest_addr));
      diff("src_addr", 64'(want.src_addr), 64'(got.src_addr));
      diff("conv_id_high", want.conv_id_high, got.conv_id_high);
      diff("conv_id_low", want.conv_id_low, got.conv_id_low);
      diff("msg_number", 64'(want.msg_number), 64'(got.msg_number));
      diff("seq_num", 64'(want.seq_num), 64'(got.seq_num));
      diff("seq_total", 64'(want.seq_total), 64'(got.seq_total));
      diff("kind_code", 64'(want.kind_code), 64'(got.kind_code));
      diff("flag_bits", 64'(want.flag_bits), 64'(got.flag_bits));
      diff("media_code", 64'(want.media_code), 64'(got.media_code));
      diff("stored_crc", 64'(want.stored_crc), 64'(got.stored_crc));
      case (want.status)
        StatusOk:     seen_ok++;
        StatusCrcErr: seen_bad++;
        default:      seen_short++;
      endcase
    endfunction
  endclass

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic [7:0]  rx_byte_i    = '0;
  logic        frame_last_i = 1'b0;
  logic        out_ready_i  = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [1:0]  status_o;
  logic [15:0] dest_addr_o;
  logic [15:0] src_addr_o;
  logic [63:0] conv_id_high_o;
  logic [63:0] conv_id_low_o;
  logic [31:0] msg_number_o;
  logic [15:0] seq_num_o;
  logic [15:0] seq_total_o;
  logic [7:0]  kind_code_o;
  logic [7:0]  flag_bits_o;
  logic [7:0]  media_code_o;
  logic [15:0] stored_crc_o;
  hdr_result_t seen_hdr;

  header_checker chk;
  logic [7:0] frame_q [$];
  bit   gaps_on = 1'b1;
  bit   no_idle = 1'b0;
  bit   hold_req = 1'b0;
  int   bytes_sent = 0;
  int   frames_sent = 0;
  int   cycles = 0;

  crc_checked_header_deframer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .rx_byte_i     (rx_byte_i),
    .frame_last_i  (frame_last_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .dest_addr_o   (dest_addr_o),
    .src_addr_o    (src_addr_o),
    .conv_id_high_o(conv_id_high_o),
    .conv_id_low_o (conv_id_low_o),
    .msg_number_o  (msg_number_o),
    .seq_num_o     (seq_num_o),
    .seq_total_o   (seq_total_o),
    .kind_code_o   (kind_code_o),
    .flag_bits_o   (flag_bits_o),
    .media_code_o  (media_code_o),
    .stored_crc_o  (stored_crc_o)
  );

  assign seen_hdr = {status_o, dest_addr_o, src_addr_o, conv_id_high_o, conv_id_low_o,
                     msg_number_o, seq_num_o, seq_total_o, kind_code_o, flag_bits_o,
                     media_code_o, stored_crc_o};

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycles, chk.pending());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) chk.check_header(seen_hdr);
  end

  // Result side: random stall bursts, short and long runs, one long hold on request, and always ready in no-idle mode.
  initial begin : receiver
    int stall_left;
    int run_left;
    int hold_left;
    stall_left = 0;
    run_left   = 0;
    hold_left  = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (no_idle) begin
        out_ready_i <= 1'b1;
      end else if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (run_left > 0) begin
        out_ready_i <= 1'b1;
        run_left--;
      end else if ($urandom_range(0, 1) == 0) begin
        stall_left = $urandom_range(1, 9) - 1;
        out_ready_i <= 1'b0;
      end else begin
        run_left = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 8) : $urandom_range(20, 80);
        out_ready_i <= 1'b1;
      end
    end
  end

  function automatic logic [7:0] pick_byte(int fill);
    logic [7:0] corners [4];
    corners = '{8'h00, 8'hFF, 8'h80, 8'h01};
    case (fill)
      FillZeros:   return 8'h00;
      FillOnes:    return 8'hFF;
      FillCorners: return corners[$urandom_range(0, 3)];
      default:     return 8'($urandom);
    endcase
  endfunction

  // Builds a full header followed by trail random bytes; a bad header gets one stored CRC bit flipped.
  task automatic make_header(input int fill, input bit good, input int trail);
    logic [15:0] c;
    c = CrcInit;
    frame_q.delete();
    for (int i = 0; i < CrcLen; i++) begin
      frame_q.push_back(pick_byte(fill));
      c = header_checker::crc_byte(c, frame_q[i]);
    end
    if (!good) c = c ^ (16'h0001 << $urandom_range(0, 15));
    frame_q.push_back(c[7:0]);
    frame_q.push_back(c[15:8]);
    repeat (trail) frame_q.push_back(8'($urandom));
  endtask

  task automatic make_short(input int len, input int fill);
    frame_q.delete();
    repeat (len) frame_q.push_back(pick_byte(fill));
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    in_valid_i   <= 1'b1;
    rx_byte_i    <= b;
    frame_last_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    chk.take_byte(b, last);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++) begin
      if (gaps_on && !no_idle && $urandom_range(0, 4) == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk_i);
      end
      send_byte(frame_q[i], i == frame_q.size() - 1);
    end
    frames_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (chk.pending() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin : stimulus
    int  kind;
    int  fill;
    int  trail;
    bit  mid_pause_done;
    mid_pause_done = 1'b0;
    chk = new();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: one-byte frame, header ending on its last byte, header with
    // trailing bytes, CRC mismatch, and a frame cut one byte short.
    make_short(1, FillOnes);
    send_frame();
    make_header(FillZeros, 1'b1, 0);
    send_frame();
    make_header(FillOnes, 1'b1, 3);
    send_frame();
    make_header(FillRandom, 1'b0, 1);
    send_frame();
    make_short(HdrLen - 1, FillCorners);
    send_frame();

    // Let everything drain, then hold the result side off while frames keep coming.
    wait_drained();
    hold_req = 1'b1;
    repeat (16) begin
      make_short(1, FillRandom);
      send_frame();
    end
    make_header(FillRandom, 1'b1, 0);
    send_frame();

    while (bytes_sent < RandBytes || frames_sent < 60) begin
      if (!mid_pause_done && bytes_sent > RandBytes / 2) begin
        wait_drained();
        mid_pause_done = 1'b1;
      end
      if (bytes_sent > RandBytes - 150) no_idle = 1'b1;
      gaps_on = ($urandom_range(0, 3) != 0);
      kind  = $urandom_range(0, 99);
      fill  = ($urandom_range(0, 9) == 0) ? $urandom_range(FillZeros, FillCorners) : FillRandom;
      trail = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (kind < 70) begin
        make_header(fill, 1'b1, trail);
      end else if (kind < 82) begin
        make_header(fill, 1'b0, trail);
      end else begin
        make_short($urandom_range(1, HdrLen - 1), fill);
      end
      send_frame();
    end

    in_valid_i <= 1'b0;
    while (chk.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d bytes in %0d frames, including a long result-side hold.",
             bytes_sent, frames_sent);
    $display("Checked %0d good headers, %0d CRC mismatches and %0d short frames.",
             chk.seen_ok, chk.seen_bad, chk.seen_short);
    if (chk.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+sv
sv/chdf_pkg.sv
sv/chdf_in_reg.sv
sv/chdf_hdr_parse.sv
sv/crc_checked_header_deframer.sv
test/crc_checked_header_deframer_tb.sv
